// ===== design/vn_pkg.sv =====
// shared constants, permutation rom and helpers for the value noise unit
`default_nettype none

package vn_pkg;

  // lattice and pipeline geometry
  localparam int TABLE_SIZE = 256;
  localparam int CELL_W     = $clog2(TABLE_SIZE);
  localparam int NUM_STAGES = 7;
  localparam int POS_W      = 32;
  localparam int NOISE_W    = 16;

  // scaled index before the divide by 255, at most 255*2^15 + 127
  localparam int M_W = 23;

  // floor(m / 255) = (m * RECIP_255) >> RECIP_SHIFT for every m below 2^24
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_255 = RECIP_W'(8421505);
  localparam logic [NOISE_W-1:0] NOISE_BIAS = NOISE_W'(16384);

  // byte permutation, a single 256 entry rom indexed by a cell byte
  localparam logic [7:0] PERM_TABLE [TABLE_SIZE] = '{
    8'd251, 8'd14,  8'd37,  8'd129, 8'd68,  8'd103, 8'd87,  8'd59,
    8'd88,  8'd80,  8'd50,  8'd32,  8'd236, 8'd26,  8'd125, 8'd12,
    8'd84,  8'd172, 8'd252, 8'd187, 8'd200, 8'd74,  8'd234, 8'd111,
    8'd17,  8'd62,  8'd161, 8'd238, 8'd226, 8'd213, 8'd192, 8'd25,
    8'd114, 8'd232, 8'd216, 8'd156, 8'd0,   8'd104, 8'd127, 8'd36,
    8'd15,  8'd7,   8'd219, 8'd72,  8'd130, 8'd243, 8'd9,   8'd167,
    8'd137, 8'd254, 8'd183, 8'd21,  8'd49,  8'd109, 8'd61,  8'd195,
    8'd6,   8'd60,  8'd170, 8'd94,  8'd171, 8'd138, 8'd163, 8'd78,
    8'd199, 8'd134, 8'd255, 8'd16,  8'd75,  8'd45,  8'd112, 8'd159,
    8'd11,  8'd140, 8'd58,  8'd181, 8'd93,  8'd162, 8'd86,  8'd148,
    8'd85,  8'd208, 8'd191, 8'd102, 8'd229, 8'd22,  8'd91,  8'd228,
    8'd105, 8'd34,  8'd169, 8'd193, 8'd96,  8'd247, 8'd250, 8'd227,
    8'd246, 8'd198, 8'd205, 8'd76,  8'd153, 8'd99,  8'd48,  8'd124,
    8'd212, 8'd40,  8'd217, 8'd135, 8'd196, 8'd47,  8'd180, 8'd144,
    8'd244, 8'd33,  8'd241, 8'd5,   8'd55,  8'd230, 8'd203, 8'd220,
    8'd29,  8'd249, 8'd8,   8'd54,  8'd18,  8'd63,  8'd133, 8'd2,
    8'd113, 8'd158, 8'd43,  8'd101, 8'd82,  8'd10,  8'd136, 8'd209,
    8'd214, 8'd30,  8'd28,  8'd154, 8'd95,  8'd142, 8'd83,  8'd67,
    8'd197, 8'd19,  8'd70,  8'd77,  8'd123, 8'd31,  8'd215, 8'd117,
    8'd131, 8'd164, 8'd186, 8'd23,  8'd132, 8'd221, 8'd69,  8'd146,
    8'd106, 8'd35,  8'd143, 8'd239, 8'd151, 8'd149, 8'd160, 8'd44,
    8'd242, 8'd1,   8'd65,  8'd177, 8'd121, 8'd139, 8'd27,  8'd157,
    8'd118, 8'd20,  8'd57,  8'd222, 8'd173, 8'd24,  8'd231, 8'd165,
    8'd175, 8'd126, 8'd4,   8'd240, 8'd64,  8'd150, 8'd189, 8'd184,
    8'd122, 8'd46,  8'd116, 8'd235, 8'd207, 8'd188, 8'd237, 8'd79,
    8'd51,  8'd52,  8'd210, 8'd100, 8'd253, 8'd223, 8'd66,  8'd218,
    8'd178, 8'd97,  8'd42,  8'd39,  8'd53,  8'd81,  8'd38,  8'd98,
    8'd248, 8'd56,  8'd119, 8'd90,  8'd152, 8'd41,  8'd92,  8'd245,
    8'd206, 8'd13,  8'd73,  8'd179, 8'd155, 8'd110, 8'd224, 8'd115,
    8'd168, 8'd145, 8'd201, 8'd176, 8'd147, 8'd202, 8'd120, 8'd194,
    8'd225, 8'd71,  8'd107, 8'd233, 8'd190, 8'd108, 8'd182, 8'd211,
    8'd166, 8'd185, 8'd174, 8'd128, 8'd3,   8'd89,  8'd141, 8'd204
  };

  // rom read, indexes wrap modulo the table size
  function automatic logic [CELL_W-1:0] perm_lookup(input logic [CELL_W-1:0] idx);
    return PERM_TABLE[idx];
  endfunction

endpackage : vn_pkg

`default_nettype wire

// ===== design/vn_in_if.sv =====
// input channel: operation and fixed-point position
`default_nettype none

interface vn_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;

  modport source (output valid, output op, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input op, input pos_x, input pos_y, output ready);
endinterface : vn_in_if

`default_nettype wire

// ===== design/vn_out_if.sv =====
// output channel: noise value in q2.14
`default_nettype none

interface vn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface : vn_out_if

`default_nettype wire

// ===== design/vn_fade.sv =====
// three stage quintic fade of one coordinate's fraction
`default_nettype none

module vn_fade #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic [2:0]                  en_i,
  input  wire logic [vn_pkg::POS_W-1:0]    pos_i,
  output logic      [FRAC_BITS:0]          fade_o
);
  import vn_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int QW = F + 6;
  localparam logic [QW-1:0]  TEN_ONE = QW'(10 * (2 ** F));
  localparam logic [F+3:0]   ONE     = (F + 4)'(2 ** F);

  logic [F-1:0]   t_q1, t2_q1;
  logic [F-1:0]   t3_q2;
  logic [F+3:0]   q_q2;
  logic [F:0]     s_q3;

  logic [2*F-1:0] sq, cube;
  logic [QW-1:0]  q_full;
  logic [2*F+3:0] prod;
  logic [F+3:0]   s_raw;

  // stage 1: t squared
  assign sq = (2 * F)'(pos_i[F-1:0]) * (2 * F)'(pos_i[F-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t_q1  <= pos_i[F-1:0];
      t2_q1 <= sq[2*F-1:F];
    end
  end

  // stage 2: t cubed and the quadratic 6t^2 - 15t + 10, modulo arithmetic
  assign cube   = (2 * F)'(t2_q1) * (2 * F)'(t_q1);
  assign q_full = QW'(6) * QW'(t2_q1) - QW'(15) * QW'(t_q1) + TEN_ONE;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      t3_q2 <= cube[2*F-1:F];
      q_q2  <= q_full[QW-1] ? '0 : q_full[F+3:0];
    end
  end

  // stage 3: product and clamp to one
  assign prod  = (2 * F + 4)'(t3_q2) * (2 * F + 4)'(q_q2);
  assign s_raw = prod[2*F+3:F];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s_q3 <= (s_raw > ONE) ? ONE[F:0] : s_raw[F:0];
    end
  end

  assign fade_o = s_q3;

endmodule : vn_fade

`default_nettype wire

// ===== design/vn_hash.sv =====
// lattice hashing through the permutation rom, three stages
`default_nettype none

module vn_hash #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic [2:0]                  en_i,
  input  wire logic                        op_i,
  input  wire logic [vn_pkg::POS_W-1:0]    pos_x_i,
  input  wire logic [vn_pkg::POS_W-1:0]    pos_y_i,
  output logic                             op_o,
  output logic      [vn_pkg::CELL_W-1:0]   a0_o,
  output logic      [vn_pkg::CELL_W-1:0]   b0_o,
  output logic      [vn_pkg::CELL_W-1:0]   a1_o,
  output logic      [vn_pkg::CELL_W-1:0]   b1_o
);
  import vn_pkg::*;

  localparam int F = FRAC_BITS;

  logic              op_q1, op_q2, op_q3;
  logic [CELL_W-1:0] h0_q1, h1_q1, iy_q1;
  logic [CELL_W-1:0] a0_q2, b0_q2, a1_q2, b1_q2;
  logic [CELL_W-1:0] a0_q3, b0_q3, a1_q3, b1_q3;

  logic [CELL_W-1:0] ix, iy1;
  logic [CELL_W-1:0] c00, c10, c01, c11;

  // stage 1: first level hash of the x cells
  assign ix = pos_x_i[F+CELL_W-1:F];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      op_q1 <= op_i;
      h0_q1 <= perm_lookup(ix);
      h1_q1 <= perm_lookup(ix + CELL_W'(1));
      iy_q1 <= pos_y_i[F+CELL_W-1:F];
    end
  end

  // stage 2: second level for 2d, the x hashes are the corners in 1d
  assign iy1 = iy_q1 + CELL_W'(1);
  assign c00 = perm_lookup(h0_q1 + iy_q1);
  assign c10 = perm_lookup(h1_q1 + iy_q1);
  assign c01 = perm_lookup(h0_q1 + iy1);
  assign c11 = perm_lookup(h1_q1 + iy1);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      op_q2 <= op_q1;
      a0_q2 <= op_q1 ? c00 : h0_q1;
      b0_q2 <= op_q1 ? c10 : h1_q1;
      a1_q2 <= c01;
      b1_q2 <= c11;
    end
  end

  // stage 3: line up with the fade result
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      op_q3 <= op_q2;
      a0_q3 <= a0_q2;
      b0_q3 <= b0_q2;
      a1_q3 <= a1_q2;
      b1_q3 <= b1_q2;
    end
  end

  assign op_o = op_q3;
  assign a0_o = a0_q3;
  assign b0_o = b0_q3;
  assign a1_o = a1_q3;
  assign b1_o = b1_q3;

endmodule : vn_hash

`default_nettype wire

// ===== design/vn_interp.sv =====
// interpolation along x and y, clamp and prescale for the output divide
`default_nettype none

module vn_interp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic [2:0]                  en_i,
  input  wire logic                        op_i,
  input  wire logic [vn_pkg::CELL_W-1:0]   a0_i,
  input  wire logic [vn_pkg::CELL_W-1:0]   b0_i,
  input  wire logic [vn_pkg::CELL_W-1:0]   a1_i,
  input  wire logic [vn_pkg::CELL_W-1:0]   b1_i,
  input  wire logic [FRAC_BITS:0]          sx_i,
  input  wire logic [FRAC_BITS:0]          sy_i,
  output logic      [vn_pkg::M_W-1:0]      m_o
);
  import vn_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int VAL_W = F + 8;
  localparam int VW    = F + 10;
  localparam int PW    = 2 * F + 11;
  localparam int SW    = PW - F;
  localparam int NW    = F + 24;
  localparam logic [VAL_W-1:0] VMAX   = VAL_W'(255 * (2 ** F));
  localparam logic [NW-1:0]    HALF_D = NW'(255 * (2 ** (F - 1)));

  // exact a*2^F + (b - a)*s, always within 0..255*2^F
  function automatic logic [VAL_W-1:0] lerp(input logic [CELL_W-1:0] a,
                                            input logic [CELL_W-1:0] b,
                                            input logic [F:0]        s);
    logic signed [CELL_W:0] dd;
    logic signed [F+1:0]    ss;
    logic signed [VW-1:0]   p;
    logic [VW-1:0]          sum;
    dd  = $signed({1'b0, b}) - $signed({1'b0, a});
    ss  = $signed({1'b0, s});
    p   = dd * ss;
    sum = VW'({a, {F{1'b0}}}) + $unsigned(p);
    return sum[VAL_W-1:0];
  endfunction

  logic              op_q4, op_q5;
  logic [VAL_W-1:0]  v0_q4, v1_q4, v0_q5;
  logic [F:0]        sy_q4;
  logic signed [PW-1:0] prod_q5;
  logic [M_W-1:0]    m_q6;

  logic signed [VAL_W:0] dv;
  logic signed [PW-1:0]  prod;
  logic signed [SW-1:0]  mix;
  logic [VAL_W-1:0]      vc;
  logic [NW-1:0]         n;

  // stage 4: both x lerps
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      op_q4 <= op_i;
      v0_q4 <= lerp(a0_i, b0_i, sx_i);
      v1_q4 <= lerp(a1_i, b1_i, sx_i);
      sy_q4 <= sy_i;
    end
  end

  // stage 5: y difference times the y fade
  assign dv   = $signed({1'b0, v1_q4}) - $signed({1'b0, v0_q4});
  assign prod = dv * $signed({1'b0, sy_q4});

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      op_q5   <= op_q4;
      v0_q5   <= v0_q4;
      prod_q5 <= prod;
    end
  end

  // stage 6: floor shift, mix, clamp, and v*2^15 + d/2 over 2^F
  assign mix = op_q5 ? ($signed(SW'(v0_q5)) + $signed(prod_q5[PW-1:F]))
                     : $signed(SW'(v0_q5));

  always_comb begin
    if (mix[SW-1]) begin
      vc = '0;
    end else if (mix[SW-2:0] > (SW - 1)'(VMAX)) begin
      vc = VMAX;
    end else begin
      vc = mix[VAL_W-1:0];
    end
  end

  assign n = (NW'(vc) << 15) + HALF_D;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      m_q6 <= n[F+M_W-1:F];
    end
  end

  assign m_o = m_q6;

endmodule : vn_interp

`default_nettype wire

// ===== design/value_noise_1d_2d_unit.sv =====
// value noise unit: 1d or 2d value noise of a q16.16 position, result in q2.14
//
// in_i carries op (0 = 1d on pos_x, 1 = 2d on pos_x and pos_y) and the signed
// fixed-point coordinates; out_o returns one noise_value item per input item,
// in order. Both channels use a valid/ready handshake.
// Seven register stages, the first loaded at the accepting edge; one item is
// accepted every cycle unless out_o.ready is low and every stage is full. The
// stages are: fraction square and first rom hash, fade cubic and second rom
// hash, fade product, x lerps, y product, mix and clamp, and the divide by 255
// done as a reciprocal multiply in the output register.
// Every stage has its own valid bit and moves whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled receiver fills the
// pipe before in_i.ready drops. A stall loses and repeats nothing.
// Reset clears all valid bits; the permutation rom is constant and needs no
// initialization, so items are taken right after reset.
`default_nettype none

module value_noise_1d_2d_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vn_in_if.sink     in_i,
  vn_out_if.source  out_o
);
  import vn_pkg::*;

  localparam int PROD_W = M_W + RECIP_W;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] en;

  logic              op_h;
  logic [CELL_W-1:0] a0, b0, a1, b1;
  logic [FRAC_BITS:0] sx, sy;
  logic [M_W-1:0]    m;
  logic [PROD_W-1:0] recip_prod;
  logic [NOISE_W-1:0] noise_q;

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_i.ready = en[0];

  // fade of each fraction, stages 1 to 3
  vn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
    .clk_i  (clk_i),
    .en_i   (en[2:0]),
    .pos_i  (in_i.pos_x),
    .fade_o (sx)
  );

  vn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
    .clk_i  (clk_i),
    .en_i   (en[2:0]),
    .pos_i  (in_i.pos_y),
    .fade_o (sy)
  );

  // corner hashing, stages 1 to 3
  vn_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
    .clk_i   (clk_i),
    .en_i    (en[2:0]),
    .op_i    (in_i.op),
    .pos_x_i (in_i.pos_x),
    .pos_y_i (in_i.pos_y),
    .op_o    (op_h),
    .a0_o    (a0),
    .b0_o    (b0),
    .a1_o    (a1),
    .b1_o    (b1)
  );

  // interpolation and prescale, stages 4 to 6
  vn_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
    .clk_i (clk_i),
    .en_i  (en[5:3]),
    .op_i  (op_h),
    .a0_i  (a0),
    .b0_i  (b0),
    .a1_i  (a1),
    .b1_i  (b1),
    .sx_i  (sx),
    .sy_i  (sy),
    .m_o   (m)
  );

  // stage 7: divide by 255 by reciprocal, remove the bias
  assign recip_prod = PROD_W'(m) * PROD_W'(RECIP_255);

  always_ff @(posedge clk_i) begin
    if (en[NUM_STAGES-1]) begin
      noise_q <= recip_prod[RECIP_SHIFT+NOISE_W-1:RECIP_SHIFT] - NOISE_BIAS;
    end
  end

  assign out_o.valid       = valid_q[NUM_STAGES-1];
  assign out_o.noise_value = $signed(noise_q);

endmodule : value_noise_1d_2d_unit

`default_nettype wire
